// ===== rtl/msh_pkg.sv =====
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types, register codes and gain helpers for the mid/side Haas delay.
// ----------------------------------------------------------------------------
package msh_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Register field widths
  localparam int GAIN_W     = 17;
  localparam int MAIN_DLY_W = 18;
  localparam int HAAS_DLY_W = 14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MID_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DELAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAN         = 3'd6;

  // Q1.16 gain constants
  localparam logic [GAIN_W-1:0] Q_ONE  = 17'h10000;
  localparam logic [GAIN_W-1:0] Q_HALF = 17'h08000;
  localparam logic [GAIN_W:0]   Q_TWO  = 18'h20000;
  localparam logic [GAIN_W-1:0] GAIN_RST = 17'h08000;

  // Sequencer program
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_H  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_WR_H   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_RD_H   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SUMDIF = 4'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_M  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_WR_M   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RD_M   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd8;

  typedef enum logic [1:0] {
    COND_NONE = 2'd0,
    COND_IN   = 2'd1,
    COND_OUT  = 2'd2
  } cond_t;

  typedef enum logic {
    MUL_HAAS = 1'b0,
    MUL_MAIN = 1'b1
  } mul_sel_t;

  typedef struct packed {
    logic              latch;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              wr_haas;
    logic              rd_haas;
    logic              sumdiff;
    logic              wr_main;
    logic              rd_main;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] next_step;
  } uctrl_t;

  typedef struct packed {
    logic run;
    logic in_xfer;
    logic out_free;
  } seq_status_t;

  // Control store: one word per step
  function automatic uctrl_t ucode(input logic [STEP_W-1:0] step);
    uctrl_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.latch = 1'b1;
        w.cond = COND_IN;
        w.next_step = STEP_MUL_H;
      end
      STEP_MUL_H: begin
        w.mul_en = 1'b1;
        w.mul_sel = MUL_HAAS;
        w.next_step = STEP_WR_H;
      end
      STEP_WR_H: begin
        w.wr_haas = 1'b1;
        w.next_step = STEP_RD_H;
      end
      STEP_RD_H: begin
        w.rd_haas = 1'b1;
        w.next_step = STEP_SUMDIF;
      end
      STEP_SUMDIF: begin
        w.sumdiff = 1'b1;
        w.next_step = STEP_MUL_M;
      end
      STEP_MUL_M: begin
        w.mul_en = 1'b1;
        w.mul_sel = MUL_MAIN;
        w.next_step = STEP_WR_M;
      end
      STEP_WR_M: begin
        w.wr_main = 1'b1;
        w.next_step = STEP_RD_M;
      end
      STEP_RD_M: begin
        w.rd_main = 1'b1;
        w.next_step = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT;
        w.next_step = STEP_IDLE;
      end
      default: begin
        w.next_step = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // Clamp a gain to 1.0
  function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
    return g[GAIN_W-1] ? Q_ONE : g;
  endfunction

  // Below center the right channel drops, left stays at 1.0
  function automatic logic [GAIN_W-1:0] pan_right_gain(input logic [GAIN_W-1:0] p);
    logic [GAIN_W-1:0] ps;
    ps = sat_gain(p);
    return (ps < Q_HALF) ? GAIN_W'({ps, 1'b0}) : Q_ONE;
  endfunction

  // Above center the left channel drops, right stays at 1.0
  function automatic logic [GAIN_W-1:0] pan_left_gain(input logic [GAIN_W-1:0] p);
    logic [GAIN_W-1:0] ps;
    ps = sat_gain(p);
    return (ps > Q_HALF) ? GAIN_W'(Q_TWO - {ps, 1'b0}) : Q_ONE;
  endfunction

endpackage

// ===== rtl/msh_seq.sv =====
// ----------------------------------------------------------------------------
// msh_seq
// Step counter over the control store, with conditional holds on the stream
// handshakes.
// ----------------------------------------------------------------------------
module msh_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  msh_pkg::seq_status_t status,
  output msh_pkg::uctrl_t      ctrl
);
  import msh_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              go;

  always_comb begin
    ctrl = ucode(step);
    unique case (ctrl.cond)
      COND_IN:  go = status.run && status.in_xfer;
      COND_OUT: go = status.run && status.out_free;
      default:  go = status.run;
    endcase
    step_next = go ? ctrl.next_step : step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/mid_side_haas_delay.sv =====
// ----------------------------------------------------------------------------
// mid_side_haas_delay
// Mid/side stereo processor with Haas pre-delay. Each stereo sample on the
// input stream is pan-scaled per channel and delayed in a per-channel Haas
// ring (delay zero returns the sample just written), then mid = L+R and
// side = L-R are scaled by their Q1.16 gains (floor) and delayed in long
// rings. Left out = mix_left + mid + side, right out = mix_right + mid - side,
// saturated to SAMPLE_BITS. Feed zeros on the mix inputs to replace, or the
// prior output to accumulate. After reset the block sweeps all rings to zero,
// one entry per cycle; no input transfer is taken during the sweep, though
// config writes are. The program then steps once per cycle, but for holds at
// the accept and emit steps: after the accept step it runs through a shared
// multiply, a ring write and a registered ring read for the Haas stage, a
// sum/difference step, the same three for the mid/side stage, and the emit
// step; a new input transfer is taken only once it is back at the accept
// step. A new input transfer is taken while a result still waits; the emit
// step then holds until the result register is free, which stalls the input.
// Depths are rounded up to powers of two. Write config only while idle.
// ----------------------------------------------------------------------------
module mid_side_haas_delay #(
  parameter int HAAS_DEPTH  = 16384,
  parameter int MAIN_DEPTH  = 262144,
  parameter int SAMPLE_BITS = 24,
  localparam int IN_W  = ((4 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msh_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_W-1:0]                s_axis_tdata,  // left_in, right_in, mix_left, mix_right
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_W-1:0]               m_axis_tdata   // left_out, right_out
);
  import msh_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int HAW   = $clog2(HAAS_DEPTH);
  localparam int MAW   = $clog2(MAIN_DEPTH);
  localparam int HSIZE = 1 << HAW;
  localparam int MSIZE = 1 << MAW;
  localparam int CLR_W = (HAW > MAW) ? HAW : MAW;
  localparam int HDW   = (HAW > HAAS_DLY_W) ? HAW : HAAS_DLY_W;
  localparam int MDW   = (MAW > MAIN_DLY_W) ? MAW : MAIN_DLY_W;
  localparam int PW    = SB + GAIN_W + 2;   // (SB+1) x (GAIN_W+1) signed

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]     mid_gain;
  logic [GAIN_W-1:0]     side_gain;
  logic [MAIN_DLY_W-1:0] mid_delay;
  logic [MAIN_DLY_W-1:0] side_delay;
  logic [HAAS_DLY_W-1:0] left_delay;
  logic [HAAS_DLY_W-1:0] right_delay;
  logic [GAIN_W-1:0]     pan;

  assign cfg_ready = 1'b1;

  // Indexes past the list are dropped; upper data bits are dropped per width
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_gain    <= GAIN_RST;
      side_gain   <= GAIN_RST;
      mid_delay   <= '0;
      side_delay  <= '0;
      left_delay  <= '0;
      right_delay <= '0;
      pan         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MID_GAIN:    mid_gain    <= cfg_data[GAIN_W-1:0];
        REG_SIDE_GAIN:   side_gain   <= cfg_data[GAIN_W-1:0];
        REG_MID_DELAY:   mid_delay   <= cfg_data[MAIN_DLY_W-1:0];
        REG_SIDE_DELAY:  side_delay  <= cfg_data[MAIN_DLY_W-1:0];
        REG_LEFT_DELAY:  left_delay  <= cfg_data[HAAS_DLY_W-1:0];
        REG_RIGHT_DELAY: right_delay <= cfg_data[HAAS_DLY_W-1:0];
        REG_PAN:         pan         <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  uctrl_t      ctrl;
  seq_status_t status;
  logic        clearing;
  logic        out_load;

  assign s_axis_tready   = ctrl.latch && !clearing;
  assign status.run      = !clearing;
  assign status.in_xfer  = s_axis_tvalid && s_axis_tready;
  assign status.out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load        = ctrl.emit && status.out_free;

  msh_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // --------------------------------------------------------------------------
  // Clearing sweep after reset
  // --------------------------------------------------------------------------
  logic [CLR_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (&clr_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input capture: samples plus gains frozen for the whole item
  // --------------------------------------------------------------------------
  logic signed [SB-1:0] l_r, r_r, ml_r, mr_r;
  logic [GAIN_W-1:0]    gl_r, gr_r, mg_r, sg_r;

  always_ff @(posedge clk) begin
    if (status.in_xfer) begin
      l_r  <= $signed(s_axis_tdata[SB-1:0]);
      r_r  <= $signed(s_axis_tdata[2*SB-1:SB]);
      ml_r <= $signed(s_axis_tdata[3*SB-1:2*SB]);
      mr_r <= $signed(s_axis_tdata[4*SB-1:3*SB]);
      gl_r <= pan_left_gain(pan);
      gr_r <= pan_right_gain(pan);
      mg_r <= sat_gain(mid_gain);
      sg_r <= sat_gain(side_gain);
    end
  end

  // --------------------------------------------------------------------------
  // Shared multipliers: pan stage, then mid/side gain stage
  // --------------------------------------------------------------------------
  logic signed [SB:0]     sum_r, diff_r;
  logic signed [SB:0]     mul_a_op, mul_b_op;
  logic signed [GAIN_W:0] mul_a_g, mul_b_g;
  logic signed [PW-1:0]   prod_a, prod_b;

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_HAAS: begin
        mul_a_op = (SB + 1)'(l_r);
        mul_b_op = (SB + 1)'(r_r);
        mul_a_g  = $signed({1'b0, gl_r});
        mul_b_g  = $signed({1'b0, gr_r});
      end
      default: begin
        mul_a_op = sum_r;
        mul_b_op = diff_r;
        mul_a_g  = $signed({1'b0, mg_r});
        mul_b_g  = $signed({1'b0, sg_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_a <= PW'(mul_a_op) * PW'(mul_a_g);
      prod_b <= PW'(mul_b_op) * PW'(mul_b_g);
    end
  end

  // --------------------------------------------------------------------------
  // Haas rings
  // --------------------------------------------------------------------------
  logic [HAW-1:0]       hpos;
  logic [HDW-1:0]       hl_diff, hr_diff;
  logic [HAW-1:0]       haas_waddr, hl_addr, hr_addr;
  logic                 haas_we;
  logic [SB-1:0]        haas_l_wdata, haas_r_wdata;
  logic [SB-1:0]        haas_l_mem [HSIZE];
  logic [SB-1:0]        haas_r_mem [HSIZE];
  logic signed [SB-1:0] dl_q, dr_q;

  assign hl_diff      = HDW'(hpos) - HDW'(left_delay);
  assign hr_diff      = HDW'(hpos) - HDW'(right_delay);
  assign hl_addr      = hl_diff[HAW-1:0];
  assign hr_addr      = hr_diff[HAW-1:0];
  assign haas_we      = clearing || ctrl.wr_haas;
  assign haas_waddr   = clearing ? clr_cnt[HAW-1:0] : hpos;
  // floor(x*g / 65536)
  assign haas_l_wdata = clearing ? '0 : prod_a[SB+15:16];
  assign haas_r_wdata = clearing ? '0 : prod_b[SB+15:16];

  always_ff @(posedge clk) begin
    if (haas_we) begin
      haas_l_mem[haas_waddr] <= haas_l_wdata;
      haas_r_mem[haas_waddr] <= haas_r_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_haas) begin
      dl_q <= $signed(haas_l_mem[hl_addr]);
      dr_q <= $signed(haas_r_mem[hr_addr]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sumdiff) begin
      sum_r  <= (SB + 1)'(dl_q) + (SB + 1)'(dr_q);
      diff_r <= (SB + 1)'(dl_q) - (SB + 1)'(dr_q);
    end
  end

  // --------------------------------------------------------------------------
  // Mid and side rings
  // --------------------------------------------------------------------------
  logic [MAW-1:0]     mpos;
  logic [MDW-1:0]     mi_diff, si_diff;
  logic [MAW-1:0]     main_waddr, mi_addr, si_addr;
  logic               main_we;
  logic [SB:0]        mid_wdata, side_wdata;
  logic [SB:0]        mid_mem  [MSIZE];
  logic [SB:0]        side_mem [MSIZE];
  logic signed [SB:0] dm_q, ds_q;

  assign mi_diff    = MDW'(mpos) - MDW'(mid_delay);
  assign si_diff    = MDW'(mpos) - MDW'(side_delay);
  assign mi_addr    = mi_diff[MAW-1:0];
  assign si_addr    = si_diff[MAW-1:0];
  assign main_we    = clearing || ctrl.wr_main;
  assign main_waddr = clearing ? clr_cnt[MAW-1:0] : mpos;
  assign mid_wdata  = clearing ? '0 : prod_a[SB+16:16];
  assign side_wdata = clearing ? '0 : prod_b[SB+16:16];

  always_ff @(posedge clk) begin
    if (main_we) begin
      mid_mem[main_waddr]  <= mid_wdata;
      side_mem[main_waddr] <= side_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_main) begin
      dm_q <= $signed(mid_mem[mi_addr]);
      ds_q <= $signed(side_mem[si_addr]);
    end
  end

  // --------------------------------------------------------------------------
  // Recombine, mix and saturate into the result register
  // --------------------------------------------------------------------------
  function automatic logic [SB-1:0] sat_out(input logic signed [SB+2:0] v);
    logic [3:0] top;
    top = v[SB+2:SB-1];
    if (top == 4'b0000 || top == 4'b1111) begin
      return v[SB-1:0];
    end
    return v[SB+2] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
  endfunction

  logic signed [SB+2:0] lsum, rsum;
  logic [SB-1:0]        left_out, right_out;

  assign lsum = (SB + 3)'(ml_r) + (SB + 3)'(dm_q) + (SB + 3)'(ds_q);
  assign rsum = (SB + 3)'(mr_r) + (SB + 3)'(dm_q) - (SB + 3)'(ds_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_out  <= sat_out(lsum);
      right_out <= sat_out(rsum);
    end
  end

  assign m_axis_tdata = OUT_W'({right_out, left_out});

  // Advance both write pointers once the result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      hpos <= '0;
      mpos <= '0;
    end else if (out_load) begin
      hpos <= hpos + 1'b1;
      mpos <= mpos + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_result_while_clearing : assert property (
    @(posedge clk) disable iff (rst) clearing |-> !m_axis_tvalid
  ) else $error("result presented during ring clearing");

  a_result_from_emit : assert property (
    @(posedge clk) disable iff (rst) $rose(m_axis_tvalid) |-> $past(ctrl.emit)
  ) else $error("result register loaded outside the emit step");

  a_pointer_advance : assert property (
    @(posedge clk) disable iff (rst)
      out_load |=> (hpos == $past(hpos) + 1'b1) && (mpos == $past(mpos) + 1'b1)
  ) else $error("ring pointers did not advance with the result");

endmodule
